// File: src/pclp_pkg.sv
// Shared types and constants for the pose command line parser.
package pclp_pkg;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LEAD,
        PH_ARGS,
        PH_DISCARD
    } line_phase_t;

    typedef enum logic [1:0] {
        DG_BEFORE,
        DG_SIGN,
        DG_DIGITS,
        DG_DONE
    } digit_phase_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_FEW   = 2'd1;
    localparam logic [1:0] ST_TOO_MANY  = 2'd2;
    localparam logic [1:0] ST_TOO_LONG  = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Index of the last argument slot (four arguments at most).
    localparam logic [1:0] LAST_ARG = 2'd3;
    // Lowest index at which a terminator gives a full result (three arguments).
    localparam logic [1:0] MIN_LAST_ARG = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [1:0]        status;
        logic [7:0]        robot_id;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] heading;
        logic              has_heading;
    } result_t;

endpackage

// File: src/pose_command_line_parser.sv
// Top level of the pose command line parser: input word register, parser core, result register.
//
// Pose command line parser. Feed one ASCII byte of a command line per input word.
// The first two bytes (command name) are skipped, then any spaces or commas,
// then comma-separated arguments are converted as atoi does. CR, LF or NUL ends
// the line and yields one result word: status 0 with id (low 8 bits of the first
// argument), x, y and heading (0 unless a fourth argument is present, flagged by
// has_heading). Errors are reported as soon as they are seen: status 1 for fewer
// than three arguments (an empty line, or the LF of a CR LF pair, gives one too),
// status 2 on the comma that opens a fifth argument, status 3 on the byte that
// brings one argument to MAX_ARG_CHARS characters; the rest of that line up to and
// including its terminator is then dropped silently. Error results carry zeros in
// every field but status.
// Rate: one word per clock while the output is not stalled. An accepted word is held
// in the input register while the parser core updates its line state and, where
// the word ends a line or shows an error, loads the result register; a word's result
// thus passes through the input register and then the result register. The result
// register frees as it is taken, so both sides may run at full rate; a stall on the
// output backs up through the input register to in_stall.
module pose_command_line_parser import pclp_pkg::*; #(
    parameter int MAX_ARG_CHARS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         char_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [7:0]         robot_id,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] heading,
    output logic               has_heading
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] char_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    res_reg;
    result_t    res;
    logic       out_free;
    logic       fire;
    logic       accept;

    // result register is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || !out_stall;
    // held word goes through the core only when its result has somewhere to land
    assign fire     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire && res.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= char_in;
        end
        if (fire && res.valid)
        begin
            res_reg <= res;
        end
    end

    pclp_core #(
        .MAX_ARG_CHARS(MAX_ARG_CHARS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (fire),
        .char_in (char_reg),
        .res     (res)
    );

    assign out_valid   = out_valid_reg;
    assign status      = res_reg.status;
    assign robot_id    = res_reg.robot_id;
    assign pos_x       = res_reg.pos_x;
    assign pos_y       = res_reg.pos_y;
    assign heading     = res_reg.heading;
    assign has_heading = res_reg.has_heading;

    // a held word is never lost while the result side is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && out_stall) |=> in_valid_reg)
        else $error("held input word dropped while output stalled");

    // a new result only appears after the core has stepped
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fire))
        else $error("result appeared without a core step");

    // error results carry nothing but the status
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status != ST_OK) |->
            (robot_id == 8'd0 && pos_x == 32'sd0 && pos_y == 32'sd0
             && heading == 32'sd0 && !has_heading))
        else $error("error result with non-zero payload");

endmodule

// File: src/pclp_core.sv
// Per-word line state and argument conversion for the pose command line parser.
module pclp_core import pclp_pkg::*; #(
    parameter int MAX_ARG_CHARS = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] char_in,
    output result_t    res
);

    localparam int CW = $clog2(MAX_ARG_CHARS);

    line_phase_t  phase_reg, phase_next;
    digit_phase_t dphase_reg, dphase_next;
    logic         hdr_reg, hdr_next;
    logic [1:0]   idx_reg, idx_next;
    logic [CW-1:0] chars_reg, chars_next;
    logic         neg_reg, neg_next;
    logic [31:0]  acc_reg, acc_next;
    logic [31:0]  args_reg [3];
    logic         arg_we;

    logic         is_term, is_space, is_comma, is_digit, is_ws;
    logic [31:0]  cur_val;
    logic [CW:0]  chars_inc;

    assign is_term  = (char_in == CH_CR) || (char_in == CH_LF) || (char_in == CH_NUL);
    assign is_space = (char_in == CH_SPACE);
    assign is_comma = (char_in == CH_COMMA);
    assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
    assign is_ws    = is_space || (char_in == CH_TAB) || (char_in == CH_VT)
                      || (char_in == CH_FF);
    assign cur_val  = neg_reg ? (32'd0 - acc_reg) : acc_reg;
    assign chars_inc = {1'b0, chars_reg} + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            dphase_reg <= DG_BEFORE;
            hdr_reg    <= 1'b0;
            idx_reg    <= '0;
            chars_reg  <= '0;
            neg_reg    <= 1'b0;
            acc_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            dphase_reg <= dphase_next;
            hdr_reg    <= hdr_next;
            idx_reg    <= idx_next;
            chars_reg  <= chars_next;
            neg_reg    <= neg_next;
            acc_reg    <= acc_next;
        end
    end

    // closed arguments; always written on this line before they are read
    always_ff @(posedge clk)
    begin
        if (arg_we)
        begin
            args_reg[idx_reg] <= cur_val;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        dphase_next = dphase_reg;
        hdr_next    = hdr_reg;
        idx_next    = idx_reg;
        chars_next  = chars_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        arg_we      = 1'b0;
        res         = '0;

        if (step)
        begin
            unique case (phase_reg)
                PH_DISCARD:
                begin
                    if (is_term)
                    begin
                        phase_next = PH_HEADER;
                        hdr_next   = 1'b0;
                        idx_next   = '0;
                        chars_next = '0;
                        neg_next   = 1'b0;
                        acc_next   = '0;
                        dphase_next = DG_BEFORE;
                    end
                end
                PH_HEADER:
                begin
                    if (is_term)
                    begin
                        res.valid  = 1'b1;
                        res.status = ST_TOO_FEW;
                        hdr_next   = 1'b0;
                    end
                    else if (hdr_reg)
                    begin
                        phase_next = PH_LEAD;
                    end
                    else
                    begin
                        hdr_next = 1'b1;
                    end
                end
                PH_LEAD, PH_ARGS:
                begin
                    if (phase_reg == PH_LEAD && (is_space || is_comma))
                    begin
                        phase_next = PH_LEAD;
                    end
                    else if (is_term)
                    begin
                        res.valid = 1'b1;
                        if (idx_reg < MIN_LAST_ARG)
                        begin
                            res.status = ST_TOO_FEW;
                        end
                        else
                        begin
                            res.status      = ST_OK;
                            res.robot_id    = args_reg[0][7:0];
                            res.pos_x       = args_reg[1];
                            res.has_heading = (idx_reg == LAST_ARG);
                            res.pos_y       = (idx_reg == LAST_ARG) ? args_reg[2] : cur_val;
                            res.heading     = (idx_reg == LAST_ARG) ? cur_val : 32'sd0;
                        end
                        phase_next  = PH_HEADER;
                        hdr_next    = 1'b0;
                        idx_next    = '0;
                        chars_next  = '0;
                        neg_next    = 1'b0;
                        acc_next    = '0;
                        dphase_next = DG_BEFORE;
                    end
                    else if (is_comma)
                    begin
                        if (idx_reg == LAST_ARG)
                        begin
                            res.valid  = 1'b1;
                            res.status = ST_TOO_MANY;
                            phase_next = PH_DISCARD;
                        end
                        else
                        begin
                            arg_we      = 1'b1;
                            phase_next  = PH_ARGS;
                            idx_next    = idx_reg + 1'b1;
                            chars_next  = '0;
                            neg_next    = 1'b0;
                            acc_next    = '0;
                            dphase_next = DG_BEFORE;
                        end
                    end
                    else
                    begin
                        phase_next = PH_ARGS;
                        // atoi-style digit handling
                        if (dphase_reg != DG_DONE)
                        begin
                            if (is_digit)
                            begin
                                acc_next    = (acc_reg << 3) + (acc_reg << 1)
                                              + {28'd0, char_in[3:0]};
                                dphase_next = DG_DIGITS;
                            end
                            else if (dphase_reg == DG_BEFORE && is_ws)
                            begin
                                dphase_next = DG_BEFORE;
                            end
                            else if (dphase_reg == DG_BEFORE
                                     && (char_in == CH_PLUS || char_in == CH_MINUS))
                            begin
                                neg_next    = (char_in == CH_MINUS);
                                dphase_next = DG_SIGN;
                            end
                            else
                            begin
                                dphase_next = DG_DONE;
                            end
                        end
                        if (chars_inc == (CW+1)'(MAX_ARG_CHARS))
                        begin
                            res.valid  = 1'b1;
                            res.status = ST_TOO_LONG;
                            phase_next = PH_DISCARD;
                        end
                        else
                        begin
                            chars_next = chars_inc[CW-1:0];
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end
    end

endmodule
